// File: rtl/key_matrix_debouncer_defines.svh
// assertion macros for the key matrix debouncer
// used by kmd_merge and key_matrix_debouncer, no other dependencies
`ifndef KEY_MATRIX_DEBOUNCER_DEFINES_SVH
`define KEY_MATRIX_DEBOUNCER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define KMD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kmd assertion failed");

// next-cycle implication, disabled during reset
`define KMD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kmd assertion failed");

`else

`define KMD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define KMD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/kmd_pkg.sv
// shared constants and types of the key matrix debouncer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package kmd_pkg;

  localparam int LANES       = 8;
  localparam int LANE_BITS   = 3;
  localparam int ROW_W       = 7;
  localparam int KEY_W       = 6;
  localparam int TIME_W      = 32;
  localparam int DEB_W       = 10;
  localparam int MAX_RESULTS = 56;
  localparam int CNT_W       = 6;

  localparam logic [DEB_W-1:0] DEB_RESET = 10'd20;

  // per-key state word held in the lane memories
  typedef struct packed {
    logic              stable;
    logic              raw;
    logic [TIME_W-1:0] change_time;
  } key_state_t;

  // sequencer to merge stage
  typedef struct packed {
    logic             start;
    logic             load;
    logic             flush;
    logic [LANES-1:0] mask;
    logic [LANES-1:0] level;
    logic [KEY_W-1:0] base;
  } mrg_ctrl_t;

  // merge stage to sequencer
  typedef struct packed {
    logic mask_empty;
    logic hold_empty;
  } mrg_stat_t;

endpackage

`default_nettype wire

// File: rtl/kmd_if.sv
// request channels of the key matrix debouncer: scan frame, event, config
// depends on kmd_pkg
`timescale 1ns / 1ps
`default_nettype none

interface kmd_in_if;
  logic                           valid;
  logic                           ready;
  logic [kmd_pkg::ROW_W-1:0]      row_0_keys;
  logic [kmd_pkg::ROW_W-1:0]      row_1_keys;
  logic [kmd_pkg::ROW_W-1:0]      row_2_keys;
  logic [kmd_pkg::ROW_W-1:0]      row_3_keys;
  logic [kmd_pkg::ROW_W-1:0]      row_4_keys;
  logic [kmd_pkg::ROW_W-1:0]      row_5_keys;
  logic [kmd_pkg::ROW_W-1:0]      row_6_keys;
  logic [kmd_pkg::ROW_W-1:0]      row_7_keys;
  logic [kmd_pkg::TIME_W-1:0]     time_ms;

  modport source (
    output valid, row_0_keys, row_1_keys, row_2_keys, row_3_keys,
           row_4_keys, row_5_keys, row_6_keys, row_7_keys, time_ms,
    input  ready
  );
  modport sink (
    input  valid, row_0_keys, row_1_keys, row_2_keys, row_3_keys,
           row_4_keys, row_5_keys, row_6_keys, row_7_keys, time_ms,
    output ready
  );
endinterface

interface kmd_out_if;
  logic                       valid;
  logic                       ready;
  logic [kmd_pkg::KEY_W-1:0]  key_index;
  logic                       pressed;
  logic [kmd_pkg::TIME_W-1:0] stable_time_ms;
  logic                       final_event;

  modport source (
    output valid, key_index, pressed, stable_time_ms, final_event,
    input  ready
  );
  modport sink (
    input  valid, key_index, pressed, stable_time_ms, final_event,
    output ready
  );
endinterface

interface kmd_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [kmd_pkg::DEB_W-1:0] debounce_ms;

  modport source (output valid, debounce_ms, input ready);
  modport sink (input valid, debounce_ms, output ready);
endinterface

`default_nettype wire

// File: rtl/kmd_ram.sv
// generic single write, single read memory with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module kmd_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 7,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/kmd_lane.sv
// one debounce lane: state memory for its keys and the per-key update
// depends on kmd_pkg and kmd_ram
`timescale 1ns / 1ps
`default_nettype none

module kmd_lane #(
  parameter int DEPTH = 7,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [AW-1:0]                 addr,
  input  wire logic                          active,
  input  wire logic                          eval,
  input  wire logic                          level,
  input  wire logic [kmd_pkg::TIME_W-1:0]    now,
  input  wire logic [kmd_pkg::DEB_W-1:0]     debounce,
  output logic                               fire,
  output logic                               new_level
);

  localparam int SW = $bits(kmd_pkg::key_state_t);

  logic [DEPTH-1:0]           vld_r;
  logic                       rd_vld_r;
  logic [SW-1:0]              rdata;
  kmd_pkg::key_state_t        cur;
  kmd_pkg::key_state_t        upd;
  logic [kmd_pkg::TIME_W-1:0] elapsed;
  logic                       hit;
  logic                       wr;

  kmd_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (wr),
    .waddr (addr),
    .wdata (SW'(upd)),
    .raddr (addr),
    .rdata (rdata)
  );

  // never-written entries read as released, time zero
  always_comb begin
    cur = rd_vld_r ? kmd_pkg::key_state_t'(rdata) : '0;
    upd.raw = level;
    upd.change_time = (level != cur.raw) ? now : cur.change_time;
    elapsed = now - upd.change_time;
    hit = (cur.stable != level) &&
          (elapsed >= kmd_pkg::TIME_W'(debounce));
    upd.stable = hit ? level : cur.stable;
  end

  assign wr        = eval && active;
  assign fire      = active && hit;
  assign new_level = level;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[addr];
      if (wr) begin
        vld_r[addr] <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/kmd_merge.sv
// merge stage: orders lane events by key, marks the last one, output register
// depends on kmd_pkg, kmd_if and the assertion macros
`timescale 1ns / 1ps
`default_nettype none
`include "key_matrix_debouncer_defines.svh"

module kmd_merge (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire kmd_pkg::mrg_ctrl_t         ctrl,
  input  wire logic [kmd_pkg::TIME_W-1:0] now,
  output kmd_pkg::mrg_stat_t              stat,
  kmd_out_if.source                       out_ch
);

  localparam int LN = kmd_pkg::LANES;
  localparam int KW = kmd_pkg::KEY_W;
  localparam int CW = kmd_pkg::CNT_W;

  logic [LN-1:0]                mask_r;
  logic [LN-1:0]                level_r;
  logic [KW-1:0]                base_r;
  logic [CW-1:0]                cnt_r;
  logic                         hold_vld_r;
  logic [KW-1:0]                hold_key_r;
  logic                         hold_pr_r;
  logic                         out_vld_r;
  logic [KW-1:0]                out_key_r;
  logic                         out_pr_r;
  logic [kmd_pkg::TIME_W-1:0]   out_time_r;
  logic                         out_final_r;

  logic [kmd_pkg::LANE_BITS-1:0] pick;
  logic                          have;
  logic                          full;
  logic                          out_free;
  logic                          take;
  logic                          drop;
  logic                          push_mid;
  logic                          push_final;

  // lowest pending lane first
  always_comb begin
    pick = '0;
    for (int i = LN - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        pick = kmd_pkg::LANE_BITS'(i);
      end
    end
  end

  assign have       = |mask_r;
  assign full       = (cnt_r == CW'(kmd_pkg::MAX_RESULTS));
  assign out_free   = !out_vld_r || out_ch.ready;
  assign drop       = have && full;
  assign take       = have && !full && (!hold_vld_r || out_free);
  assign push_mid   = take && hold_vld_r;
  assign push_final = !have && ctrl.flush && hold_vld_r && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r     <= '0;
      cnt_r      <= '0;
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (ctrl.start) begin
        cnt_r <= '0;
      end else if (take) begin
        cnt_r <= cnt_r + 1'b1;
      end

      if (ctrl.load) begin
        mask_r  <= ctrl.mask;
        level_r <= ctrl.level;
        base_r  <= ctrl.base;
      end else if (take || drop) begin
        mask_r[pick] <= 1'b0;
      end

      if (take) begin
        hold_vld_r <= 1'b1;
        hold_key_r <= base_r + KW'(pick);
        hold_pr_r  <= level_r[pick];
      end else if (push_final) begin
        hold_vld_r <= 1'b0;
      end

      if (push_mid || push_final) begin
        out_vld_r   <= 1'b1;
        out_key_r   <= hold_key_r;
        out_pr_r    <= hold_pr_r;
        out_time_r  <= now;
        out_final_r <= push_final;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign stat.mask_empty = !have;
  assign stat.hold_empty = !hold_vld_r;

  assign out_ch.valid          = out_vld_r;
  assign out_ch.key_index      = out_key_r;
  assign out_ch.pressed        = out_pr_r;
  assign out_ch.stable_time_ms = out_time_r;
  assign out_ch.final_event    = out_final_r;

  `KMD_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(kmd_pkg::MAX_RESULTS))
  `KMD_ASSERT_IMP(a_load_empty, clk, rst_n, ctrl.load, mask_r == '0)
  `KMD_ASSERT_NXT(a_final_out, clk, rst_n, push_final, !hold_vld_r && out_vld_r && out_final_r)

endmodule

`default_nettype wire

// File: rtl/key_matrix_debouncer.sv
// top level of the key matrix debouncer: frame capture, group sequencer,
// eight debounce lanes and the merge stage; depends on kmd_pkg, kmd_if,
// kmd_lane, kmd_merge and the assertion macros
`timescale 1ns / 1ps
`default_nettype none
`include "key_matrix_debouncer_defines.svh"

// Time-based debouncer for a scanned key matrix. One request on in_ch is one
// scan frame (a column word of 7 bits per row plus a millisecond timestamp);
// every key whose raw level has differed from its debounced level for at least
// debounce_ms milliseconds flips and produces one request on out_ch, in
// ascending key order, the last of the frame flagged by final_event. A frame
// with no change produces nothing. Keys are handled by eight lanes, one key
// per lane, a group of eight keys at a time; each lane keeps its keys' state
// (raw level, debounced level, time of last raw change) in a small memory
// that reads as all released after reset. A frame is taken in the idle
// state, then passes through memory read, update and merge check for each
// group of eight keys, and ends with a flush that sends the held last event,
// if any, flagged as final. The merge stage emits at most one event per
// cycle while out_ch does not stall, which is what stretches a frame with
// many events. in_ch is ready only between frames; the result register lets
// a new frame in while the last event still waits on out_ch. debounce_ms is
// written through cfg_ch (always ready), resets to 20 and should only be
// changed between frames, since a write lands at once in the lane
// comparators.

module key_matrix_debouncer #(
  parameter int KEY_COUNT    = 56,
  parameter int ROW_COUNT    = 8,
  parameter int COLUMN_COUNT = 7
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  kmd_in_if.sink     in_ch,
  kmd_out_if.source  out_ch,
  kmd_cfg_if.sink    cfg_ch
);

  localparam int LN     = kmd_pkg::LANES;
  localparam int LB     = kmd_pkg::LANE_BITS;
  localparam int GROUPS = (KEY_COUNT + LN - 1) / LN;
  localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int SEEN_W = GROUPS * LN;
  localparam int SIW    = GW + LB;
  localparam logic [GW-1:0] LAST_GRP = GW'(GROUPS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_SCAN,
    S_FLUSH
  } state_t;

  state_t                      state_r;
  logic [GW-1:0]               grp_r;
  logic [SEEN_W-1:0]           seen_r;
  logic [SEEN_W-1:0]           seen_nxt;
  logic [kmd_pkg::TIME_W-1:0]  now_r;
  logic [kmd_pkg::DEB_W-1:0]   deb_r;
  logic [7:0]                  rows [8];
  logic                        in_acc;

  logic [LN-1:0]               lane_fire;
  logic [LN-1:0]               lane_lvl;
  logic [LN-1:0]               lane_act;

  kmd_pkg::mrg_ctrl_t          mrg_ctrl;
  kmd_pkg::mrg_stat_t          mrg_stat;

  // frame request handshake
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // column bit c of row r is key r*COLUMN_COUNT+c; out-of-range keys dropped
  always_comb begin
    rows[0] = {1'b0, in_ch.row_0_keys};
    rows[1] = {1'b0, in_ch.row_1_keys};
    rows[2] = {1'b0, in_ch.row_2_keys};
    rows[3] = {1'b0, in_ch.row_3_keys};
    rows[4] = {1'b0, in_ch.row_4_keys};
    rows[5] = {1'b0, in_ch.row_5_keys};
    rows[6] = {1'b0, in_ch.row_6_keys};
    rows[7] = {1'b0, in_ch.row_7_keys};
    seen_nxt = '0;
    for (int r = 0; r < 8; r++) begin
      for (int c = 0; c < 8; c++) begin
        if (r < ROW_COUNT && c < COLUMN_COUNT &&
            (r * COLUMN_COUNT + c) < KEY_COUNT) begin
          seen_nxt[SIW'(r * COLUMN_COUNT + c)] = rows[r][c];
        end
      end
    end
  end

  // group sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      grp_r   <= '0;
      deb_r   <= kmd_pkg::DEB_RESET;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        deb_r <= cfg_ch.debounce_ms;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            seen_r  <= seen_nxt;
            now_r   <= in_ch.time_ms;
            grp_r   <= '0;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          // lane memories present this group's state next cycle
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          // lanes write back, merge stage takes the event mask
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (mrg_stat.mask_empty) begin
            if (grp_r == LAST_GRP) begin
              state_r <= S_FLUSH;
            end else begin
              grp_r   <= grp_r + 1'b1;
              state_r <= S_READ;
            end
          end
        end
        S_FLUSH: begin
          // last held event leaves flagged as final
          if (mrg_stat.hold_empty) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // one lane per key position within a group
  for (genvar j = 0; j < LN; j++) begin : g_lane
    assign lane_act[j] = (int'(grp_r) * LN + j) < KEY_COUNT;

    kmd_lane #(.DEPTH(GROUPS)) u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .addr      (grp_r),
      .active    (lane_act[j]),
      .eval      (state_r == S_EVAL),
      .level     (seen_r[{grp_r, LB'(j)}]),
      .now       (now_r),
      .debounce  (deb_r),
      .fire      (lane_fire[j]),
      .new_level (lane_lvl[j])
    );
  end

  always_comb begin
    mrg_ctrl.start = in_acc;
    mrg_ctrl.load  = (state_r == S_EVAL);
    mrg_ctrl.flush = (state_r == S_FLUSH);
    mrg_ctrl.mask  = lane_fire;
    mrg_ctrl.level = lane_lvl;
    mrg_ctrl.base  = kmd_pkg::KEY_W'({grp_r, LB'(0)});
  end

  kmd_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (mrg_ctrl),
    .now    (now_r),
    .stat   (mrg_stat),
    .out_ch (out_ch)
  );

  `KMD_ASSERT_IMP(a_eval_empty, clk, rst_n, state_r == S_EVAL, mrg_stat.mask_empty)
  `KMD_ASSERT_IMP(a_idle_drained, clk, rst_n, state_r == S_IDLE, mrg_stat.mask_empty && mrg_stat.hold_empty)
  `KMD_ASSERT_IMP(a_grp_range, clk, rst_n, 1'b1, grp_r <= LAST_GRP)

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// self-checking bench for key_matrix_debouncer: scan frames in, key events out
// depends on kmd_pkg, kmd_if and the debouncer rtl
`timescale 1ns / 1ps

module tb_top;

  localparam int KEYS = 56;
  localparam int ROWS = 8;
  localparam int COLS = 7;
  // the block has a single register, debounce_ms, at index 0
  localparam int DEBOUNCE_REG = 0;
  // long enough for a frame with no events to finish
  localparam int DRAIN_CYCLES = 100;
  localparam int LONG_HOLD = 400;
  localparam longint CYCLE_LIMIT = 8_000_000;

  typedef struct packed {
    bit [ROWS-1:0][kmd_pkg::ROW_W-1:0] rows;
    bit [kmd_pkg::TIME_W-1:0]          now;
  } scan_frame_t;

  typedef struct packed {
    bit [kmd_pkg::KEY_W-1:0]  key_index;
    bit                       pressed;
    bit [kmd_pkg::TIME_W-1:0] stable_time_ms;
    bit                       final_event;
  } key_event_t;

  // per-key debounce state and the queue of key events still owed by the block
  class debounce_tracker;
    bit                       raw_lvl[KEYS];
    bit                       stable_lvl[KEYS];
    bit [kmd_pkg::TIME_W-1:0] change_at[KEYS];
    bit [kmd_pkg::DEB_W-1:0]  hold_ms;
    key_event_t               due[$];
    int                       errors;

    function new();
      hold_ms = kmd_pkg::DEB_RESET;
      errors = 0;
    endfunction

    function void write_reg(int idx, bit [kmd_pkg::DEB_W-1:0] value);
      if (idx == DEBOUNCE_REG) begin
        hold_ms = value;
      end
    endfunction

    // walk the keys in ascending order, queue one event per accepted change
    function void note_frame(scan_frame_t f);
      key_event_t               ev;
      bit                       lvl;
      bit [kmd_pkg::TIME_W-1:0] held;
      int                       reported;
      reported = 0;
      for (int k = 0; k < KEYS; k++) begin
        lvl = f.rows[k / COLS][k % COLS];
        if (lvl != raw_lvl[k]) begin
          raw_lvl[k] = lvl;
          change_at[k] = f.now;
        end
        // elapsed time wraps modulo 2^32
        held = f.now - change_at[k];
        if (stable_lvl[k] != raw_lvl[k] && held >= hold_ms) begin
          stable_lvl[k] = raw_lvl[k];
          if (reported < kmd_pkg::MAX_RESULTS) begin
            ev.key_index = kmd_pkg::KEY_W'(k);
            ev.pressed = raw_lvl[k];
            ev.stable_time_ms = f.now;
            ev.final_event = 1'b0;
            due.push_back(ev);
            reported++;
          end
        end
      end
      if (reported > 0) begin
        due[due.size() - 1].final_event = 1'b1;
      end
    endfunction

    function void check_event(key_event_t got);
      key_event_t want;
      if (due.size() == 0) begin
        $error("event for key %0d arrived with none expected", got.key_index);
        errors++;
        return;
      end
      want = due.pop_front();
      if (got.key_index != want.key_index) begin
        $error("key_index expected %0d actual %0d", want.key_index, got.key_index);
        errors++;
      end
      if (got.pressed != want.pressed) begin
        $error("pressed expected %0d actual %0d", want.pressed, got.pressed);
        errors++;
      end
      if (got.stable_time_ms != want.stable_time_ms) begin
        $error("stable_time_ms expected %0h actual %0h",
               want.stable_time_ms, got.stable_time_ms);
        errors++;
      end
      if (got.final_event != want.final_event) begin
        $error("final_event expected %0d actual %0d", want.final_event, got.final_event);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  kmd_in_if  in_ch();
  kmd_out_if out_ch();
  kmd_cfg_if cfg_ch();

  key_matrix_debouncer u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  debounce_tracker tracker = new();

  bit                       key_down[KEYS];  // physical key positions
  bit [kmd_pkg::TIME_W-1:0] clock_ms;
  int                       cur_deb = 20;
  bit                       steady_flow;     // no idling on either side
  bit                       hold_off_req;    // asks the receiver for a long stall
  longint                   cycle_count = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("key_matrix_debouncer test failed");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (steady_flow) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // observe accepted requests on all three channels
  always @(posedge clk) begin
    scan_frame_t f;
    key_event_t  got;
    if (rst_n === 1'b1) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        tracker.write_reg(DEBOUNCE_REG, cfg_ch.debounce_ms);
      end
      if (in_ch.valid && in_ch.ready) begin
        f.rows[0] = in_ch.row_0_keys;
        f.rows[1] = in_ch.row_1_keys;
        f.rows[2] = in_ch.row_2_keys;
        f.rows[3] = in_ch.row_3_keys;
        f.rows[4] = in_ch.row_4_keys;
        f.rows[5] = in_ch.row_5_keys;
        f.rows[6] = in_ch.row_6_keys;
        f.rows[7] = in_ch.row_7_keys;
        f.now = in_ch.time_ms;
        tracker.note_frame(f);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.key_index = out_ch.key_index;
        got.pressed = out_ch.pressed;
        got.stable_time_ms = out_ch.stable_time_ms;
        got.final_event = out_ch.final_event;
        tracker.check_event(got);
      end
    end
  end

  // event receiver: bursts of ready with random stalls, one long stall on request
  initial begin
    int on_len;
    int off_len;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      on_len = $urandom_range(1, 20);
      out_ch.ready <= 1'b1;
      repeat (on_len) @(posedge clk);
      off_len = pick_gap();
      if (off_len > 0) begin
        out_ch.ready <= 1'b0;
        repeat (off_len) @(posedge clk);
      end
    end
  end

  task automatic send_frame(input scan_frame_t f);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.row_0_keys <= f.rows[0];
    in_ch.row_1_keys <= f.rows[1];
    in_ch.row_2_keys <= f.rows[2];
    in_ch.row_3_keys <= f.rows[3];
    in_ch.row_4_keys <= f.rows[4];
    in_ch.row_5_keys <= f.rows[5];
    in_ch.row_6_keys <= f.rows[6];
    in_ch.row_7_keys <= f.rows[7];
    in_ch.time_ms <= f.now;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop offering frames until every owed event has come out
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (tracker.due.size() != 0);
  endtask

  task automatic set_debounce(input bit [kmd_pkg::DEB_W-1:0] ms);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.debounce_ms <= ms;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_deb = ms;
  endtask

  function automatic scan_frame_t uniform_frame(bit [kmd_pkg::ROW_W-1:0] cols,
                                                bit [kmd_pkg::TIME_W-1:0] t);
    scan_frame_t f;
    for (int r = 0; r < ROWS; r++) begin
      f.rows[r] = cols;
    end
    f.now = t;
    return f;
  endfunction

  // one key per row on a diagonal, covering key 0 and key 55
  function automatic scan_frame_t diag_frame(bit [kmd_pkg::TIME_W-1:0] t, bit key0);
    scan_frame_t f;
    for (int r = 0; r < COLS; r++) begin
      f.rows[r] = kmd_pkg::ROW_W'(1 << r);
    end
    f.rows[7] = 7'h40;
    f.rows[0][0] = key0;
    f.now = t;
    return f;
  endfunction

  // keys move a few at a time, rarely all at once, with contact bounce, plus
  // noise frames; time steps scale with the debounce setting so keys settle often
  task automatic random_frames(input int count, input int drain_at, input int hold_at);
    scan_frame_t              f;
    bit [kmd_pkg::TIME_W-1:0] step;
    int                       r;
    int                       k;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_off_req = 1'b1;
      if (i == drain_at) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 70) step = $urandom_range(0, cur_deb / 3 + 2);
      else if (r < 92) step = $urandom_range(0, cur_deb + cur_deb / 2 + 4);
      else if (r < 99) step = $urandom_range(0, 3 * cur_deb + 10);
      else step = $urandom;
      clock_ms = clock_ms + step;
      if ($urandom_range(0, 49) == 0) begin
        for (int j = 0; j < KEYS; j++) key_down[j] = !key_down[j];
      end else begin
        repeat ($urandom_range(0, 3)) begin
          k = $urandom_range(0, KEYS - 1);
          key_down[k] = !key_down[k];
        end
      end
      for (int j = 0; j < KEYS; j++) begin
        f.rows[j / COLS][j % COLS] = key_down[j];
      end
      // bounce: a few keys read inverted in this frame only
      if ($urandom_range(0, 9) < 3) begin
        repeat ($urandom_range(1, 3)) begin
          k = $urandom_range(0, KEYS - 1);
          f.rows[k / COLS][k % COLS] = !f.rows[k / COLS][k % COLS];
        end
      end
      if ($urandom_range(0, 99) < 7) begin
        for (int j = 0; j < ROWS; j++) f.rows[j] = kmd_pkg::ROW_W'($urandom);
      end
      f.now = clock_ms;
      send_frame(f);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.row_0_keys <= '0;
    in_ch.row_1_keys <= '0;
    in_ch.row_2_keys <= '0;
    in_ch.row_3_keys <= '0;
    in_ch.row_4_keys <= '0;
    in_ch.row_5_keys <= '0;
    in_ch.row_6_keys <= '0;
    in_ch.row_7_keys <= '0;
    in_ch.time_ms <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.debounce_ms <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset debounce of 20 ms: nothing before 20 ms, all 56 keys at once after
    send_frame(uniform_frame(7'h00, 32'd0));
    send_frame(uniform_frame(7'h7f, 32'd5));
    send_frame(uniform_frame(7'h7f, 32'd24));
    send_frame(uniform_frame(7'h7f, 32'd25));
    send_frame(uniform_frame(7'h00, 32'd100));
    send_frame(uniform_frame(7'h00, 32'd120));
    // single keys, then a bounce on key 0 that never settles to a new level
    send_frame(diag_frame(32'd200, 1'b1));
    send_frame(diag_frame(32'd300, 1'b1));
    send_frame(diag_frame(32'd310, 1'b0));
    send_frame(diag_frame(32'd315, 1'b1));
    send_frame(diag_frame(32'd340, 1'b1));
    // change recorded just before the timer wraps, accepted just after
    send_frame(uniform_frame(7'h2a, 32'hffff_fff0));
    send_frame(uniform_frame(7'h2a, 32'h0000_0003));
    send_frame(uniform_frame(7'h2a, 32'h0000_0004));
    send_frame(uniform_frame(7'h55, 32'hffff_ffff));
    send_frame(uniform_frame(7'h55, 32'h0000_0013));

    clock_ms = $urandom;
    random_frames(60, -1, -1);

    // zero debounce: a change is taken in the frame it shows up
    set_debounce(10'd0);
    send_frame(uniform_frame(7'h7f, 32'h0000_0013));
    send_frame(uniform_frame(7'h00, 32'h0000_0013));
    clock_ms = $urandom;
    random_frames(75, 40, 10);

    set_debounce(10'd1023);
    clock_ms = $urandom;
    random_frames(70, -1, -1);

    set_debounce(10'd1);
    steady_flow = 1'b1;
    random_frames(70, -1, -1);
    steady_flow = 1'b0;

    set_debounce(kmd_pkg::DEB_W'($urandom_range(2, 60)));
    random_frames(75, -1, -1);

    // short debounce while the timer crosses its wrap point
    set_debounce(10'd5);
    clock_ms = 32'hffff_ffc0;
    random_frames(80, -1, -1);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("key_matrix_debouncer test passed");
    end else begin
      $display("key_matrix_debouncer test failed");
    end
    $finish;
  end

endmodule
